// ----- src/mse_pkg.sv -----
`timescale 1ns / 1ps

package mse_pkg;

  // Data memory depth in words (power of two) and program counter reset value
  localparam int unsigned MSE_DATA_WORDS       = 1024;
  localparam logic [31:0] MSE_START_ADDR_RESET = 32'h0040_0000;

  // Field widths of the transfer payloads
  localparam int unsigned INSTR_W = 32;
  localparam int unsigned OUT_W   = 112;

  // Major opcodes
  localparam logic [5:0] OP_RTYPE = 6'd0;
  localparam logic [5:0] OP_J     = 6'd2;
  localparam logic [5:0] OP_JAL   = 6'd3;
  localparam logic [5:0] OP_BEQ   = 6'd4;
  localparam logic [5:0] OP_BNE   = 6'd5;
  localparam logic [5:0] OP_BGTZ  = 6'd7;
  localparam logic [5:0] OP_ADDI  = 6'd8;
  localparam logic [5:0] OP_ADDIU = 6'd9;
  localparam logic [5:0] OP_SLTI  = 6'd10;
  localparam logic [5:0] OP_ORI   = 6'd13;
  localparam logic [5:0] OP_LUI   = 6'd15;
  localparam logic [5:0] OP_LW    = 6'd35;
  localparam logic [5:0] OP_SW    = 6'd43;

  // R-type function codes
  localparam logic [5:0] FN_ADD  = 6'd32;
  localparam logic [5:0] FN_ADDU = 6'd33;
  localparam logic [5:0] FN_SUB  = 6'd34;
  localparam logic [5:0] FN_SUBU = 6'd35;
  localparam logic [5:0] FN_SLT  = 6'd42;
  localparam logic [5:0] FN_SLTU = 6'd43;

  localparam logic [4:0] LINK_REG = 5'd31;

  // Outcome of executing one instruction word
  typedef struct packed {
    logic [31:0] next_pc;
    logic        halted;
    logic        flag_n;
    logic        flag_z;
    logic        flag_v;
    logic        flag_c;
    logic        reg_written;
    logic [4:0]  dest_index;
    logic [31:0] dest_value;
    logic        store_done;
    logic [31:0] store_address;
    logic        load;
    logic [31:0] mem_addr;
    logic [31:0] store_data;
  } exe_res_t;

endpackage

// ----- src/mse_regfile.sv -----
`timescale 1ns / 1ps

module mse_regfile
  import mse_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic [4:0]  ra_idx,
  input  logic [4:0]  rb_idx,
  input  logic        we,
  input  logic [4:0]  w_idx,
  input  logic [31:0] w_data,
  output logic [31:0] ra_data,
  output logic [31:0] rb_data
);

  logic [31:0] mem [32];
  logic [31:0] vld_r;
  logic [31:0] ra_data_r;
  logic [31:0] rb_data_r;
  logic        ra_vld_r;
  logic        rb_vld_r;

  // Write port and registered read ports
  always_ff @(posedge clk) begin
    if (we) begin
      mem[w_idx] <= w_data;
    end
    ra_data_r <= mem[ra_idx];
    rb_data_r <= mem[rb_idx];
  end

  // Mark entries written since reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      ra_vld_r <= 1'b0;
      rb_vld_r <= 1'b0;
    end else begin
      if (we) begin
        vld_r[w_idx] <= 1'b1;
      end
      ra_vld_r <= vld_r[ra_idx];
      rb_vld_r <= vld_r[rb_idx];
    end
  end

  // Unwritten entries read as zero
  assign ra_data = ra_vld_r ? ra_data_r : '0;
  assign rb_data = rb_vld_r ? rb_data_r : '0;

endmodule

// ----- src/mse_dmem.sv -----
`timescale 1ns / 1ps

module mse_dmem
  import mse_pkg::*;
#(
  parameter int unsigned DATA_WORDS = MSE_DATA_WORDS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        re,
  input  logic        we,
  input  logic [31:0] addr,
  input  logic [31:0] wdata,
  output logic [31:0] rdata,
  output logic        busy
);

  localparam int unsigned AW = $clog2(DATA_WORDS);

  logic [31:0]   mem [DATA_WORDS];
  logic [31:0]   rdata_r;
  logic [AW-1:0] idx;
  logic [AW-1:0] clr_idx_r;
  logic          clr_busy_r;

  // Word index: drop the byte offset, wrap at the depth
  assign idx = addr[AW+1:2];

  // Sweep the whole array with zeros after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_idx_r  <= '0;
    end else if (clr_busy_r) begin
      clr_idx_r <= clr_idx_r + AW'(1);
      if (clr_idx_r == AW'(DATA_WORDS - 1)) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  // Single write port, one registered read port held while stalled
  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      mem[clr_idx_r] <= '0;
    end else if (we) begin
      mem[idx] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[idx];
    end
  end

  assign rdata = rdata_r;
  assign busy  = clr_busy_r;

endmodule

// ----- src/mse_exec.sv -----
`timescale 1ns / 1ps

module mse_exec
  import mse_pkg::*;
(
  input  logic [31:0] word,
  input  logic [31:0] pc,
  input  logic        halt_mark,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output exe_res_t    res
);

  logic [5:0]  op;
  logic [4:0]  rt;
  logic [4:0]  rd;
  logic [5:0]  fn;
  logic [31:0] imm_z;
  logic [31:0] simm;
  logic [31:0] pc4;
  logic [31:0] br_target;
  logic [32:0] sum_ab;
  logic [32:0] dif_ab;
  logic [32:0] sum_ai;
  logic [31:0] r;
  logic        wr;

  assign op    = word[31:26];
  assign rt    = word[20:16];
  assign rd    = word[15:11];
  assign fn    = word[5:0];
  assign imm_z = {16'h0000, word[15:0]};
  assign simm  = {{16{word[15]}}, word[15:0]};
  assign pc4   = pc + 32'd4;

  assign br_target = pc4 + {simm[29:0], 2'b00};
  assign sum_ab    = {1'b0, a} + {1'b0, b};
  assign dif_ab    = {1'b0, a} - {1'b0, b};
  assign sum_ai    = {1'b0, a} + {1'b0, simm};

  always_comb begin
    res     = '0;
    r       = '0;
    wr      = 1'b0;
    res.next_pc    = pc4;
    res.mem_addr   = sum_ai[31:0];
    res.store_data = b;

    if (halt_mark || word == '0) begin
      // Halt: hold the program counter, report nothing else
      res.next_pc = pc;
      res.halted  = 1'b1;
    end else begin
      unique case (op)
        OP_RTYPE: begin
          res.dest_index = rd;
          unique case (fn)
            FN_ADD: begin
              r  = sum_ab[31:0];
              wr = 1'b1;
              res.flag_v = (a[31] ^ r[31]) & (b[31] ^ r[31]);
              res.flag_n = r[31];
            end
            FN_ADDU: begin
              r  = sum_ab[31:0];
              wr = 1'b1;
              res.flag_c = sum_ab[32];
            end
            FN_SUB: begin
              r  = dif_ab[31:0];
              wr = 1'b1;
              res.flag_v = (a[31] ^ b[31]) & (a[31] ^ r[31]);
              res.flag_n = r[31];
            end
            FN_SUBU: begin
              r  = dif_ab[31:0];
              wr = 1'b1;
              res.flag_c = dif_ab[32];
              res.flag_n = r[31];
            end
            FN_SLT: begin
              r  = {31'd0, $signed(a) < $signed(b)};
              wr = 1'b1;
            end
            FN_SLTU: begin
              r  = {31'd0, dif_ab[32]};
              wr = 1'b1;
            end
            default: begin
            end
          endcase
          res.flag_z = wr & (r == '0);
        end
        OP_J, OP_JAL: begin
          res.next_pc = {pc4[31:28], word[25:0], 2'b00};
          if (op == OP_JAL) begin
            r  = pc4;
            wr = 1'b1;
            res.dest_index = LINK_REG;
          end
        end
        OP_BEQ: begin
          if (a == b) begin
            res.next_pc = br_target;
          end
        end
        OP_BNE: begin
          if (a != b) begin
            res.next_pc = br_target;
          end
        end
        OP_BGTZ: begin
          if (!a[31] && a != '0) begin
            res.next_pc = br_target;
          end
        end
        OP_ADDI: begin
          r  = sum_ai[31:0];
          wr = 1'b1;
          res.dest_index = rt;
          res.flag_v = (a[31] ^ r[31]) & (simm[31] ^ r[31]);
          res.flag_n = r[31];
          res.flag_z = (r == '0);
        end
        OP_ADDIU: begin
          r  = sum_ai[31:0];
          wr = 1'b1;
          res.dest_index = rt;
          res.flag_c = sum_ai[32];
          res.flag_z = (r == '0);
        end
        OP_SLTI: begin
          r  = {31'd0, $signed(a) < $signed(simm)};
          wr = 1'b1;
          res.dest_index = rt;
        end
        OP_ORI: begin
          r  = a | imm_z;
          wr = 1'b1;
          res.dest_index = rt;
          res.flag_z = (r == '0);
        end
        OP_LUI: begin
          r  = {word[15:0], 16'h0000};
          wr = 1'b1;
          res.dest_index = rt;
          res.flag_z = (r == '0);
        end
        OP_LW: begin
          // Value and zero flag are filled in once the read data returns
          res.load = 1'b1;
          wr = 1'b1;
          res.dest_index = rt;
        end
        OP_SW: begin
          res.store_done    = 1'b1;
          res.store_address = sum_ai[31:0];
        end
        default: begin
        end
      endcase

      // Drop writes to r0, and report no destination when nothing is written
      if (wr && res.dest_index != '0) begin
        res.reg_written = 1'b1;
        res.dest_value  = r;
      end else begin
        res.dest_index = '0;
      end
    end
  end

endmodule

// ----- src/mips_subset_instruction_executor_core.sv -----
`timescale 1ns / 1ps
// Pipeline: input register loaded by an input transfer, then load/result stage, then output
// register driving out_tvalid; the data memory read port sets the middle stage.
// Throughput: one instruction per cycle while the output is not back-pressured and the data
// memory is not being cleared; results are forwarded to the next instruction.
// Reset (rst_n, synchronous, active low) clears control state, then the data memory is
// swept to zero word by word with in_tready low; configuration is taken meanwhile.

module mips_subset_instruction_executor_core
  import mse_pkg::*;
#(
  parameter int unsigned DATA_WORDS = MSE_DATA_WORDS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // Configuration: start_address
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [31:0]          cfg_data,
  // Input: instruction_word
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [INSTR_W-1:0]   in_tdata,
  // Output, from bit 0: next_pc[31:0], halted, flag_negative, flag_zero, flag_overflow,
  // flag_carry, reg_written, dest_index[4:0], dest_value[31:0], store_done,
  // store_address[31:0], zero padding[3:0]
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [OUT_W-1:0]     out_tdata
);

  logic              in_xfer;
  logic              x_adv;
  logic              m_adv;
  logic              dm_busy;

  logic              x_vld_r;
  logic [31:0]       x_word_r;
  logic              m_vld_r;
  exe_res_t          m_res_r;
  logic              o_vld_r;
  logic [OUT_W-1:0]  o_data_r;

  logic [31:0]       pc_r;
  logic              halt_r;

  logic [4:0]        rd_a_idx;
  logic [4:0]        rd_b_idx;
  logic [31:0]       rf_a;
  logic [31:0]       rf_b;
  logic [4:0]        x_rs;
  logic [4:0]        x_rt;
  logic [31:0]       op_a;
  logic [31:0]       op_b;

  logic              wrec_vld_r;
  logic [4:0]        wrec_idx_r;
  logic [31:0]       wrec_val_r;

  logic [31:0]       dm_rdata;
  exe_res_t          x_res;
  logic [31:0]       m_val;
  logic              m_flag_z;
  logic              rf_we;
  logic [OUT_W-1:0]  m_pack;

  // Stage advance: move when the next stage is empty or moving
  assign m_adv     = m_vld_r && (!o_vld_r || out_tready);
  assign x_adv     = x_vld_r && (!m_vld_r || m_adv);
  assign in_tready = !dm_busy && (!x_vld_r || x_adv);
  assign in_xfer   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_vld_r <= 1'b0;
    end else if (in_xfer) begin
      x_vld_r <= 1'b1;
    end else if (x_adv) begin
      x_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      x_word_r <= in_tdata;
    end
  end

  // Read the register file for the instruction that executes next cycle
  assign x_rs     = x_word_r[25:21];
  assign x_rt     = x_word_r[20:16];
  assign rd_a_idx = (!x_vld_r || x_adv) ? in_tdata[25:21] : x_rs;
  assign rd_b_idx = (!x_vld_r || x_adv) ? in_tdata[20:16] : x_rt;

  mse_regfile u_regfile (
    .clk     (clk),
    .rst_n   (rst_n),
    .ra_idx  (rd_a_idx),
    .rb_idx  (rd_b_idx),
    .we      (rf_we),
    .w_idx   (m_res_r.dest_index),
    .w_data  (m_val),
    .ra_data (rf_a),
    .rb_data (rf_b)
  );

  // Record the write made at the last edge, which the registered read missed
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wrec_vld_r <= 1'b0;
    end else begin
      wrec_vld_r <= rf_we;
    end
  end

  always_ff @(posedge clk) begin
    if (rf_we) begin
      wrec_idx_r <= m_res_r.dest_index;
      wrec_val_r <= m_val;
    end
  end

  // Forward the pending write first, then the one just made
  always_comb begin
    if (m_vld_r && m_res_r.reg_written && m_res_r.dest_index == x_rs) begin
      op_a = m_val;
    end else if (wrec_vld_r && wrec_idx_r == x_rs) begin
      op_a = wrec_val_r;
    end else begin
      op_a = rf_a;
    end
    if (m_vld_r && m_res_r.reg_written && m_res_r.dest_index == x_rt) begin
      op_b = m_val;
    end else if (wrec_vld_r && wrec_idx_r == x_rt) begin
      op_b = wrec_val_r;
    end else begin
      op_b = rf_b;
    end
  end

  mse_exec u_exec (
    .word      (x_word_r),
    .pc        (pc_r),
    .halt_mark (halt_r),
    .a         (op_a),
    .b         (op_b),
    .res       (x_res)
  );

  // PC and halt mark commit as the instruction leaves the input register; a cfg load wins
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r   <= MSE_START_ADDR_RESET;
      halt_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      pc_r <= cfg_data;
    end else if (x_adv) begin
      pc_r <= x_res.next_pc;
      if (x_res.halted) begin
        halt_r <= 1'b1;
      end
    end
  end

  mse_dmem #(
    .DATA_WORDS (DATA_WORDS)
  ) u_dmem (
    .clk   (clk),
    .rst_n (rst_n),
    .re    (x_adv),
    .we    (x_adv && x_res.store_done),
    .addr  (x_res.mem_addr),
    .wdata (x_res.store_data),
    .rdata (dm_rdata),
    .busy  (dm_busy)
  );

  // Load/result stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_vld_r <= 1'b0;
    end else if (x_adv) begin
      m_vld_r <= 1'b1;
    end else if (m_adv) begin
      m_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (x_adv) begin
      m_res_r <= x_res;
    end
  end

  // Complete loads with the returned word
  always_comb begin
    m_val    = m_res_r.dest_value;
    m_flag_z = m_res_r.flag_z;
    if (m_res_r.load) begin
      m_val    = m_res_r.reg_written ? dm_rdata : '0;
      m_flag_z = (dm_rdata == '0);
    end
  end

  assign rf_we = m_adv && m_res_r.reg_written;

  assign m_pack = {4'b0000, m_res_r.store_address, m_res_r.store_done, m_val,
                   m_res_r.dest_index, m_res_r.reg_written, m_res_r.flag_c,
                   m_res_r.flag_v, m_flag_z, m_res_r.flag_n, m_res_r.halted,
                   m_res_r.next_pc};

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_vld_r <= 1'b0;
    end else if (m_adv) begin
      o_vld_r <= 1'b1;
    end else if (out_tready) begin
      o_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (m_adv) begin
      o_data_r <= m_pack;
    end
  end

  assign out_tvalid = o_vld_r;
  assign out_tdata  = o_data_r;

endmodule

// ----- bench/tb_mips_subset_instruction_executor_core.sv -----
`timescale 1ns / 1ps

module tb_mips_subset_instruction_executor_core;
  import mse_pkg::*;

  localparam int unsigned STALL_LIMIT = 5000;
  localparam int unsigned LONG_HOLD   = 200;
  localparam int unsigned HOLD_AT     = 400;

  // Result transfer layout, most significant field first
  typedef struct packed {
    logic [3:0]  pad;
    logic [31:0] store_address;
    logic        store_done;
    logic [31:0] dest_value;
    logic [4:0]  dest_index;
    logic        reg_written;
    logic        flag_c;
    logic        flag_v;
    logic        flag_z;
    logic        flag_n;
    logic        halted;
    logic [31:0] next_pc;
  } exec_result_t;

  typedef struct {
    logic [31:0]  word;
    bit           typed;
    exec_result_t outcome;
  } program_row_t;

  logic               clk        = 1'b0;
  logic               rst_n      = 1'b0;
  logic               cfg_valid  = 1'b0;
  logic               cfg_ready;
  logic [31:0]        cfg_data   = '0;
  logic               in_tvalid  = 1'b0;
  logic               in_tready;
  logic [INSTR_W-1:0] in_tdata   = '0;
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [OUT_W-1:0]   out_tdata;

  // Architectural state of the executor as the bench sees it
  logic [31:0] core_pc;
  logic [31:0] core_start;
  logic [31:0] gpr [32];
  logic [31:0] data_mem [MSE_DATA_WORDS];
  logic        core_halted;

  exec_result_t pending_outcomes [$];
  program_row_t program_rows [$];
  int unsigned  fault_count   = 0;
  int unsigned  results_seen  = 0;
  int unsigned  idle_cycles   = 0;
  int unsigned  sender_burst  = 0;
  int unsigned  receiver_burst = 0;

  mips_subset_instruction_executor_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #5 clk = ~clk;

  // Clear the bench copy of the core state
  task automatic clear_core_state();
    core_start  = MSE_START_ADDR_RESET;
    core_pc     = MSE_START_ADDR_RESET;
    core_halted = 1'b0;
    for (int i = 0; i < 32; i++) gpr[i] = '0;
    for (int i = 0; i < MSE_DATA_WORDS; i++) data_mem[i] = '0;
  endtask

  function automatic int unsigned mem_slot(input logic [31:0] addr);
    return addr[31:2] % MSE_DATA_WORDS;
  endfunction

  // Execute one instruction word on the bench state and return its outcome
  function automatic exec_result_t execute_word(input logic [31:0] word);
    exec_result_t res;
    logic [5:0]   opc;
    logic [5:0]   fcode;
    logic [4:0]   rs_i;
    logic [4:0]   rt_i;
    logic [4:0]   rd_i;
    logic [4:0]   dst;
    logic [31:0]  simm;
    logic [31:0]  a;
    logic [31:0]  b;
    logic [31:0]  r;
    logic [31:0]  t;
    logic [31:0]  npc;
    logic         wr;
    logic         known;
    res = '0;
    if (core_halted || word == '0) begin
      core_halted = 1'b1;
      res.next_pc = core_pc;
      res.halted  = 1'b1;
      return res;
    end
    opc   = word[31:26];
    rs_i  = word[25:21];
    rt_i  = word[20:16];
    rd_i  = word[15:11];
    fcode = word[5:0];
    simm  = {{16{word[15]}}, word[15:0]};
    a     = gpr[rs_i];
    b     = gpr[rt_i];
    npc   = core_pc + 32'd4;
    wr    = 1'b0;
    dst   = '0;
    r     = '0;
    case (opc)
      OP_RTYPE: begin
        known = 1'b1;
        case (fcode)
          FN_ADD: begin
            r = a + b;
            t = (a ^ r) & (b ^ r);
            res.flag_v = t[31];
            res.flag_n = r[31];
          end
          FN_ADDU: begin
            r = a + b;
            res.flag_c = (r < a);
          end
          FN_SUB: begin
            r = a - b;
            t = (a ^ b) & (a ^ r);
            res.flag_v = t[31];
            res.flag_n = r[31];
          end
          FN_SUBU: begin
            r = a - b;
            res.flag_c = (a < b);
            res.flag_n = r[31];
          end
          FN_SLT:  r = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
          FN_SLTU: r = (a < b) ? 32'd1 : 32'd0;
          default: known = 1'b0;
        endcase
        if (known) begin
          res.flag_z = (r == '0);
          wr  = 1'b1;
          dst = rd_i;
        end
      end
      OP_J, OP_JAL: begin
        if (opc == OP_JAL) begin
          wr  = 1'b1;
          dst = LINK_REG;
          r   = npc;
        end
        npc = {npc[31:28], word[25:0], 2'b00};
      end
      OP_BEQ:  if (a == b) npc = npc + (simm << 2);
      OP_BNE:  if (a != b) npc = npc + (simm << 2);
      OP_BGTZ: if ($signed(a) > 0) npc = npc + (simm << 2);
      OP_ADDI: begin
        r = a + simm;
        t = (a ^ r) & (simm ^ r);
        res.flag_v = t[31];
        res.flag_n = r[31];
        res.flag_z = (r == '0);
        wr  = 1'b1;
        dst = rt_i;
      end
      OP_ADDIU: begin
        r = a + simm;
        res.flag_c = (r < a);
        res.flag_z = (r == '0);
        wr  = 1'b1;
        dst = rt_i;
      end
      OP_SLTI: begin
        r   = ($signed(a) < $signed(simm)) ? 32'd1 : 32'd0;
        wr  = 1'b1;
        dst = rt_i;
      end
      OP_ORI: begin
        r = a | {16'h0000, word[15:0]};
        res.flag_z = (r == '0);
        wr  = 1'b1;
        dst = rt_i;
      end
      OP_LUI: begin
        r = {word[15:0], 16'h0000};
        res.flag_z = (r == '0);
        wr  = 1'b1;
        dst = rt_i;
      end
      OP_LW: begin
        r = data_mem[mem_slot(a + simm)];
        res.flag_z = (r == '0);
        wr  = 1'b1;
        dst = rt_i;
      end
      OP_SW: begin
        res.store_done    = 1'b1;
        res.store_address = a + simm;
        data_mem[mem_slot(a + simm)] = b;
      end
      default: ;
    endcase
    // r0 keeps zero: flags stand, the write is dropped
    if (wr && dst != '0) begin
      gpr[dst]        = r;
      res.reg_written = 1'b1;
      res.dest_index  = dst;
      res.dest_value  = r;
    end
    core_pc     = npc;
    res.next_pc = npc;
    return res;
  endfunction

  function automatic exec_result_t write_outcome(input logic [31:0] pc, input logic carry,
                                                 input logic [4:0] dst, input logic [31:0] val);
    exec_result_t res;
    res             = '0;
    res.next_pc     = pc;
    res.flag_c      = carry;
    res.reg_written = 1'b1;
    res.dest_index  = dst;
    res.dest_value  = val;
    return res;
  endfunction

  // Random gap before the next transfer, with runs of back-to-back transfers
  function automatic int unsigned draw_gap(inout int unsigned burst);
    if (burst > 0) begin
      burst--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      burst = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 7);
  endfunction

  function automatic logic [4:0] random_reg();
    return ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31)) : 5'($urandom_range(0, 7));
  endfunction

  function automatic logic [15:0] random_imm();
    case ($urandom_range(0, 7))
      0:       return 16'h0000;
      1:       return 16'h7FFF;
      2:       return 16'h8000;
      3:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // Mostly well-formed instructions over a few busy registers, some noise
  function automatic logic [31:0] random_word();
    logic [31:0] w;
    logic [5:0]  fcode;
    logic [5:0]  opc;
    logic [4:0]  rs_i;
    logic [4:0]  rt_i;
    logic [4:0]  rd_i;
    logic [15:0] imm;
    rs_i = random_reg();
    rt_i = random_reg();
    rd_i = random_reg();
    imm  = random_imm();
    case ($urandom_range(0, 19))
      0, 1, 2, 3, 4, 5: begin
        case ($urandom_range(0, 5))
          0:       fcode = FN_ADD;
          1:       fcode = FN_ADDU;
          2:       fcode = FN_SUB;
          3:       fcode = FN_SUBU;
          4:       fcode = FN_SLT;
          default: fcode = FN_SLTU;
        endcase
        w = {OP_RTYPE, rs_i, rt_i, rd_i, 5'($urandom_range(0, 31)), fcode};
      end
      6:  w = {OP_ADDI, rs_i, rt_i, imm};
      7:  w = {OP_ADDIU, rs_i, rt_i, imm};
      8:  w = {OP_SLTI, rs_i, rt_i, imm};
      9:  w = {OP_ORI, rs_i, rt_i, imm};
      10: w = {OP_LUI, 5'($urandom_range(0, 31)), rt_i, imm};
      11, 12, 13, 14: begin
        opc = ($urandom_range(0, 1) == 0) ? OP_LW : OP_SW;
        // keep half the accesses in a small window so loads see earlier stores
        if ($urandom_range(0, 1) == 0)
          w = {opc, 5'd0, rt_i, 16'($urandom_range(0, 15) * 4)};
        else
          w = {opc, rs_i, rt_i, imm};
      end
      15: begin
        case ($urandom_range(0, 2))
          0:       opc = OP_BEQ;
          1:       opc = OP_BNE;
          default: opc = OP_BGTZ;
        endcase
        w = {opc, rs_i, rt_i, imm};
      end
      16: w = {($urandom_range(0, 1) == 0) ? OP_J : OP_JAL, 26'($urandom)};
      17: w = {6'($urandom_range(16, 34)), 26'($urandom)};
      18: begin
        fcode = ($urandom_range(0, 1) == 0) ? 6'($urandom_range(0, 31))
                                             : 6'($urandom_range(44, 63));
        w = {OP_RTYPE, rs_i, rt_i, rd_i, 5'($urandom_range(0, 31)), fcode};
      end
      default: w = $urandom;
    endcase
    if (w == '0) w = 32'h0000_0001;
    return w;
  endfunction

  // Offer one instruction and log its outcome once the transfer happens
  task automatic issue_instruction(input logic [31:0] word, input bit typed,
                                   input exec_result_t typed_outcome);
    int unsigned  gap;
    exec_result_t predicted;
    gap = draw_gap(sender_burst);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= word;
    do @(posedge clk); while (!in_tready);
    predicted = execute_word(word);
    pending_outcomes.push_back(typed ? typed_outcome : predicted);
  endtask

  task automatic run_random(input int unsigned count);
    repeat (count) issue_instruction(random_word(), 1'b0, '0);
    in_tvalid <= 1'b0;
  endtask

  // Load a new start address once the core has drained
  task automatic set_start_address(input logic [31:0] addr);
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= addr;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid  <= 1'b0;
    core_start = addr;
    core_pc    = addr;
  endtask

  task automatic compare_field(input string label, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      if (fault_count < 10)
        $display("%0t: %s mismatch: expected %h, got %h", $time, label, want, got);
      fault_count++;
    end
  endtask

  task automatic check_outcome(input exec_result_t got);
    exec_result_t want;
    results_seen++;
    if (pending_outcomes.size() == 0) begin
      if (fault_count < 10)
        $display("%0t: result with nothing outstanding: %h", $time, got);
      fault_count++;
      return;
    end
    want = pending_outcomes.pop_front();
    compare_field("next_pc", want.next_pc, got.next_pc);
    compare_field("halted", want.halted, got.halted);
    compare_field("flag_negative", want.flag_n, got.flag_n);
    compare_field("flag_zero", want.flag_z, got.flag_z);
    compare_field("flag_overflow", want.flag_v, got.flag_v);
    compare_field("flag_carry", want.flag_c, got.flag_c);
    compare_field("reg_written", want.reg_written, got.reg_written);
    compare_field("dest_index", want.dest_index, got.dest_index);
    compare_field("dest_value", want.dest_value, got.dest_value);
    compare_field("store_done", want.store_done, got.store_done);
    compare_field("store_address", want.store_address, got.store_address);
  endtask

  function automatic void add_row(input logic [31:0] word);
    program_rows.push_back('{word: word, typed: 1'b0, outcome: '0});
  endfunction

  function automatic void add_typed_row(input logic [31:0] word, input exec_result_t outcome);
    program_rows.push_back('{word: word, typed: 1'b1, outcome: outcome});
  endfunction

  // Receive results with random back-pressure and one long hold-off
  initial begin
    int unsigned stall;
    bit          held;
    held = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (!held && results_seen == HOLD_AT) begin
        held = 1'b1;
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        stall = draw_gap(receiver_burst);
        if (stall > 0) begin
          out_tready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      check_outcome(exec_result_t'(out_tdata));
    end
  end

  // Abort when no transfer of any kind happens for too long
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("mips_subset_instruction_executor_core regression: fail");
      $finish;
    end
  end

  initial begin
    clear_core_state();

    // Hand-written program: extremes, every operation, r0 writes, unknown codes
    add_typed_row(32'h3C01_FFFF,
                  write_outcome(MSE_START_ADDR_RESET + 32'd4, 1'b0, 5'd1, 32'hFFFF_0000));
    add_typed_row(32'h3421_FFFF,
                  write_outcome(MSE_START_ADDR_RESET + 32'd8, 1'b0, 5'd1, 32'hFFFF_FFFF));
    add_typed_row(32'h0021_1021,
                  write_outcome(MSE_START_ADDR_RESET + 32'd12, 1'b1, 5'd2, 32'hFFFF_FFFE));
    add_row(32'h3C03_7FFF);   // lui r3: most positive upper half
    add_row(32'h3463_FFFF);   // ori r3 reads the freshly written r3
    add_row(32'h0063_2020);   // add overflows
    add_row(32'h0023_2822);   // sub down to the most negative value
    add_row(32'h0001_2823);   // subu with borrow
    add_row(32'h0020_302A);   // slt, signed
    add_row(32'h0001_382B);   // sltu, unsigned
    add_row(32'h2068_0001);   // addi overflows
    add_row(32'h2429_0001);   // addiu wraps to zero with carry
    add_row(32'h282A_0000);   // slti against zero
    add_row(32'h280A_8000);   // slti against the most negative immediate
    add_row(32'hAC01_FFFC);   // sw to the top of the address space
    add_row(32'h8C0B_0FFC);   // lw from the aliased word
    add_row(32'h0021_0020);   // add into r0: flags only
    add_row(32'h0020_67E0);   // shamt bits set, ignored
    add_row(32'h0400_0000);   // unknown opcode
    add_row(32'hFC00_0000);   // unknown opcode, all ones
    add_row(32'h0000_003F);   // unknown function code
    add_row(32'h1000_FFFF);   // beq taken back onto itself
    add_row(32'h1020_0004);   // beq not taken
    add_row(32'h1420_7FFF);   // bne taken, furthest forward
    add_row(32'h1C60_0001);   // bgtz taken on a positive value
    add_row(32'h1C20_0001);   // bgtz not taken on a negative value
    add_row(32'h0BFF_FFFF);   // j to the top of the region
    add_row(32'h0C00_0000);   // jal to the bottom of the region

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (program_rows[i])
      issue_instruction(program_rows[i].word, program_rows[i].typed, program_rows[i].outcome);
    in_tvalid <= 1'b0;

    // Random phases over several start addresses
    set_start_address(32'h0000_0000);
    run_random(300);
    set_start_address(32'hFFFF_FFFF);
    run_random(300);
    set_start_address($urandom);
    run_random(300);
    set_start_address(32'hFFFF_FFFC);
    run_random(300);
    set_start_address(MSE_START_ADDR_RESET);
    run_random(200);

    // Stop on a zero word, then keep feeding a halted core
    issue_instruction(32'h0000_0000, 1'b0, '0);
    run_random(3);

    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fault_count == 0 && pending_outcomes.size() == 0)
      $display("mips_subset_instruction_executor_core regression: pass");
    else
      $display("mips_subset_instruction_executor_core regression: fail");
    $finish;
  end

endmodule
